>>> design/rrrp_pkg.sv
// ----------------------------------------------------------------------------
// rrrp_pkg
// Types and constants shared by the replica placement block: node entry,
// request and response items, register indexes and command codes.
// ----------------------------------------------------------------------------
package rrrp_pkg;

   localparam int MAX_NODES       = 8;
   localparam int NODE_W          = 3;
   localparam int BLOCKS_PER_NODE = 64;
   localparam int BLOCK_W         = 6;
   localparam int FREE_W          = 7;
   localparam int COUNT_W         = 4;
   localparam int BYTES_PER_MAP   = BLOCKS_PER_NODE / 8;
   localparam int BYTE_IDX_W      = 3;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_NODE_COUNT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PINNED_MODE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PINNED_NODE = 2'd2;

   localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = 4'd1;

   localparam logic CMD_PLACE  = 1'b0;
   localparam logic CMD_STATUS = 1'b1;

   typedef struct packed {
      logic                       cmd;
      logic [NODE_W-1:0]          node_sel;
      logic                       online;
      logic [FREE_W-1:0]          free_blocks;
      logic [BLOCKS_PER_NODE-1:0] used_map;
   } req_type;

   typedef struct packed {
      logic               status;
      logic               pending;
      logic [NODE_W-1:0]  first_node;
      logic [BLOCK_W-1:0] first_block;
      logic [NODE_W-1:0]  second_node;
      logic [BLOCK_W-1:0] second_block;
   } rsp_type;

   typedef struct packed {
      logic                       online;
      logic [FREE_W-1:0]          free;
      logic [BLOCKS_PER_NODE-1:0] map;
   } node_entry_type;

endpackage

>>> design/round_robin_replica_placement.sv
// ----------------------------------------------------------------------------
// round_robin_replica_placement
// Places the two copies of a data block on storage nodes by a round-robin
// walk; node state lives in an 8-entry memory read, modified and written back.
// ----------------------------------------------------------------------------
// Usage:
//   Request: drive req_item and raise start; the item is taken at an edge
//   where busy is low. cmd STATUS loads one node's online flag, free count
//   and bitmap; cmd PLACE places two copies (or pins them in pinned mode).
//   Response: rsp_item is valid for one cycle while rsp_strobe is high; the
//   receiver cannot stall, it must take the item in that cycle.
//   Registers: csr_we, csr_index, csr_wdata write node_count, pinned_mode,
//   pinned_node; write only while busy is low and no response is due.
// Sequence:
//   status load: response in the cycle after accept, busy stays low.
//   pinned place: memory read, then ST_PIN, then the registered response.
//   round-robin place: per node visited, a memory read then the eligibility
//   check; per copy, the bit search; then write-back of the first copy's
//   node, then the second's; the run grows with the number of skipped nodes.
//   The single read port of the node memory paces the walk.
// Reset: node entries read as zero until loaded, pointer zero, node_count 1.
// ----------------------------------------------------------------------------
module round_robin_replica_placement (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  rrrp_pkg::req_type                   req_item,
   output logic                                rsp_strobe,
   output rrrp_pkg::rsp_type                   rsp_item,
   input  logic                                csr_we,
   input  logic [rrrp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rrrp_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import rrrp_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_READ  = 3'd1;
   localparam logic [2:0] ST_CHECK = 3'd2;
   localparam logic [2:0] ST_BIT   = 3'd3;
   localparam logic [2:0] ST_WB0   = 3'd4;
   localparam logic [2:0] ST_WB1   = 3'd5;
   localparam logic [2:0] ST_PIN   = 3'd6;

   node_entry_type mem [MAX_NODES];

   logic [2:0]            state_ff, state_in;
   logic                  copy_ff, copy_in;
   logic [NODE_W-1:0]     p_ff, p_in;
   logic [COUNT_W-1:0]    cnt_ff, cnt_in;
   logic [COUNT_W-1:0]    s_ff, s_in;
   logic [NODE_W-1:0]     node0_ff, node0_in;
   logic [BLOCK_W-1:0]    blk0_ff, blk0_in;
   logic [NODE_W-1:0]     node1_ff, node1_in;
   logic [BLOCK_W-1:0]    blk1_ff, blk1_in;
   node_entry_type        held0_ff, held0_in;
   node_entry_type        held1_ff, held1_in;
   node_entry_type        cand_ff, cand_in;
   logic [NODE_W-1:0]     cand_node_ff, cand_node_in;
   logic [BYTE_IDX_W-1:0] byte_idx_ff, byte_idx_in;
   logic [7:0]            byte_ff, byte_in;
   logic                  hit_ff, hit_in;
   logic [NODE_W-1:0]     rr_ff, rr_in;
   logic [COUNT_W-1:0]    node_count_ff;
   logic                  pinned_mode_ff;
   logic [NODE_W-1:0]     pinned_node_ff;
   logic [MAX_NODES-1:0]  valid_ff;
   node_entry_type        rd_data_ff;
   logic                  rd_valid_ff;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   rsp_type               rsp_item_ff, rsp_item_in;

   logic                  rd_en;
   logic [NODE_W-1:0]     rd_addr;
   logic                  wr_en;
   logic [NODE_W-1:0]     wr_addr;
   node_entry_type        wr_data;

   logic                  accept;
   node_entry_type        entry;
   node_entry_type        upd;
   logic [BLOCK_W-1:0]    blk;
   logic [2:0]            bit_sel;
   logic [NODE_W-1:0]     p_next;
   logic [COUNT_W-1:0]    cnt_clamp;

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

   always_comb begin
      state_in      = state_ff;
      copy_in       = copy_ff;
      p_in          = p_ff;
      cnt_in        = cnt_ff;
      s_in          = s_ff;
      node0_in      = node0_ff;
      blk0_in       = blk0_ff;
      node1_in      = node1_ff;
      blk1_in       = blk1_ff;
      held0_in      = held0_ff;
      held1_in      = held1_ff;
      cand_in       = cand_ff;
      cand_node_in  = cand_node_ff;
      byte_idx_in   = byte_idx_ff;
      byte_in       = byte_ff;
      hit_in        = hit_ff;
      rr_in         = rr_ff;
      rsp_strobe_in = 1'b0;
      rsp_item_in   = rsp_item_ff;
      rd_en         = 1'b0;
      rd_addr       = p_ff;
      wr_en         = 1'b0;
      wr_addr       = p_ff;
      wr_data       = held0_ff;
      entry         = '0;
      upd           = cand_ff;
      bit_sel       = '0;
      blk           = '0;

      if (node_count_ff == '0) begin
         cnt_clamp = COUNT_W'(1);
      end else if (node_count_ff > COUNT_W'(MAX_NODES)) begin
         cnt_clamp = COUNT_W'(MAX_NODES);
      end else begin
         cnt_clamp = node_count_ff;
      end

      if (({1'b0, p_ff} + COUNT_W'(1)) == cnt_ff) begin
         p_next = '0;
      end else begin
         p_next = p_ff + NODE_W'(1);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_item.cmd == CMD_STATUS) begin
                  wr_en          = 1'b1;
                  wr_addr        = req_item.node_sel;
                  wr_data.online = req_item.online;
                  wr_data.free   = req_item.free_blocks;
                  wr_data.map    = req_item.used_map;
                  rsp_strobe_in  = 1'b1;
                  rsp_item_in    = '0;
               end else if (pinned_mode_ff) begin
                  rd_en    = 1'b1;
                  rd_addr  = pinned_node_ff;
                  state_in = ST_PIN;
               end else begin
                  cnt_in   = cnt_clamp;
                  p_in     = ({1'b0, rr_ff} >= cnt_clamp) ? '0 : rr_ff;
                  s_in     = '0;
                  copy_in  = 1'b0;
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            rd_en    = 1'b1;
            rd_addr  = p_ff;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (copy_ff && (p_ff == node0_ff)) begin
               entry = held0_ff;
            end else if (rd_valid_ff) begin
               entry = rd_data_ff;
            end
            cand_in      = entry;
            cand_node_in = p_ff;
            p_in         = p_next;
            hit_in       = 1'b0;
            byte_idx_in  = '0;
            for (int k = BYTES_PER_MAP - 1; k >= 0; k--) begin
               if (!(&entry.map[8*k +: 8])) begin
                  hit_in      = 1'b1;
                  byte_idx_in = BYTE_IDX_W'(k);
               end
            end
            byte_in = entry.map[8*byte_idx_in +: 8];
            if ((entry.free != '0) && entry.online) begin
               state_in = ST_BIT;
            end else if ((s_ff + COUNT_W'(1)) == cnt_ff) begin
               rsp_strobe_in      = 1'b1;
               rsp_item_in        = '0;
               rsp_item_in.status = 1'b1;
               state_in           = ST_IDLE;
            end else begin
               s_in     = s_ff + COUNT_W'(1);
               state_in = ST_READ;
            end
         end
         ST_BIT: begin
            for (int i = 7; i >= 0; i--) begin
               if (!byte_ff[i]) begin
                  bit_sel = 3'(i);
               end
            end
            blk      = {byte_idx_ff, bit_sel};
            upd.map  = cand_ff.map | (BLOCKS_PER_NODE'(1) << blk);
            upd.free = cand_ff.free - FREE_W'(1);
            if (!hit_ff) begin
               rsp_strobe_in      = 1'b1;
               rsp_item_in        = '0;
               rsp_item_in.status = 1'b1;
               state_in           = ST_IDLE;
            end else if (!copy_ff) begin
               node0_in = cand_node_ff;
               blk0_in  = blk;
               held0_in = upd;
               copy_in  = 1'b1;
               s_in     = '0;
               state_in = ST_READ;
            end else begin
               node1_in = cand_node_ff;
               blk1_in  = blk;
               held1_in = upd;
               state_in = ST_WB0;
            end
         end
         ST_WB0: begin
            wr_en    = 1'b1;
            wr_addr  = node0_ff;
            wr_data  = held0_ff;
            state_in = ST_WB1;
         end
         ST_WB1: begin
            wr_en                    = 1'b1;
            wr_addr                  = node1_ff;
            wr_data                  = held1_ff;
            rr_in                    = p_ff;
            rsp_strobe_in            = 1'b1;
            rsp_item_in              = '0;
            rsp_item_in.first_node   = node0_ff;
            rsp_item_in.first_block  = blk0_ff;
            rsp_item_in.second_node  = node1_ff;
            rsp_item_in.second_block = blk1_ff;
            state_in                 = ST_IDLE;
         end
         ST_PIN: begin
            entry = rd_valid_ff ? rd_data_ff : '0;
            wr_en        = 1'b1;
            wr_addr      = pinned_node_ff;
            wr_data      = entry;
            wr_data.free = (entry.free >= FREE_W'(2)) ? (entry.free - FREE_W'(2)) : '0;
            rsp_strobe_in           = 1'b1;
            rsp_item_in             = '0;
            rsp_item_in.pending     = 1'b1;
            rsp_item_in.first_node  = pinned_node_ff;
            rsp_item_in.second_node = pinned_node_ff;
            state_in                = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff  <= mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rr_ff          <= '0;
         valid_ff       <= '0;
         rsp_strobe_ff  <= 1'b0;
         node_count_ff  <= NODE_COUNT_RESET;
         pinned_mode_ff <= 1'b0;
         pinned_node_ff <= '0;
      end else begin
         state_ff      <= state_in;
         rr_ff         <= rr_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (csr_we) begin
            unique case (csr_index)
               CSR_NODE_COUNT:  node_count_ff  <= csr_wdata;
               CSR_PINNED_MODE: pinned_mode_ff <= csr_wdata[0];
               CSR_PINNED_NODE: pinned_node_ff <= csr_wdata[NODE_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      copy_ff      <= copy_in;
      p_ff         <= p_in;
      cnt_ff       <= cnt_in;
      s_ff         <= s_in;
      node0_ff     <= node0_in;
      blk0_ff      <= blk0_in;
      node1_ff     <= node1_in;
      blk1_ff      <= blk1_in;
      held0_ff     <= held0_in;
      held1_ff     <= held1_in;
      cand_ff      <= cand_in;
      cand_node_ff <= cand_node_in;
      byte_idx_ff  <= byte_idx_in;
      byte_ff      <= byte_in;
      hit_ff       <= hit_in;
      rsp_item_ff  <= rsp_item_in;
   end

endmodule
